@@ src/ssq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants for the step sequencer core: event codes,
// encoder targets, value limits, reset values and the packed item layouts.
// ----------------------------------------------------------------------------
package ssq_pkg;

  // Event codes carried on the input channel's tuser.
  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_START_STOP  = 3'd1,
    OP_SET_CURRENT = 3'd2,
    OP_PATTERN_BTN = 3'd3,
    OP_ENCODER     = 3'd4,
    OP_NEXT_SET    = 3'd5,
    OP_TEST        = 3'd6,
    OP_UNUSED      = 3'd7
  } ssq_op_t;

  // What the encoder acts on.
  typedef enum logic [1:0] {
    SET_NOTE     = 2'd0,
    SET_TEMPO    = 2'd1,
    SET_VELOCITY = 2'd2
  } ssq_setting_t;

  // Field widths.
  localparam int NOTE_W  = 7;
  localparam int TEMPO_W = 8;
  localparam int LED_W   = 16;

  // Limits of the encoder targets.
  localparam logic [NOTE_W-1:0]  NOTE_MIN  = 7'd1;
  localparam logic [NOTE_W-1:0]  NOTE_MAX  = 7'd127;
  localparam logic [NOTE_W-1:0]  VEL_MIN   = 7'd0;
  localparam logic [NOTE_W-1:0]  VEL_MAX   = 7'd127;
  localparam logic [TEMPO_W-1:0] TEMPO_MIN = 8'd1;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX = 8'd255;

  // Reset values.
  localparam logic [NOTE_W-1:0]  RST_BEAT_NOTE = 7'd36;
  localparam logic [NOTE_W-1:0]  RST_CHOSEN    = 7'd39;
  localparam logic [NOTE_W-1:0]  RST_VELOCITY  = 7'd127;
  localparam logic [TEMPO_W-1:0] RST_TEMPO     = 8'd120;

  // Input item payload, lowest bits last.
  typedef struct packed {
    logic       pad;
    logic       enc_dir;
    logic       hold_held;
    logic       clear_held;
    logic [3:0] step_index;
  } ssq_in_t;

  // Result item payload, lowest bits last.
  typedef struct packed {
    logic [4:0]         pad;
    logic               is_playing;
    logic [1:0]         setting_index;
    logic [NOTE_W-1:0]  note_selected;
    logic [TEMPO_W-1:0] tempo_bpm;
    logic               beat_led;
    logic [LED_W-1:0]   led_mask;
    logic               sound_trigger;
    logic [NOTE_W-1:0]  velocity;
    logic [NOTE_W-1:0]  note_on_number;
    logic               note_on_valid;
    logic [NOTE_W-1:0]  note_off_number;
    logic               note_off_valid;
  } ssq_result_t;

endpackage

@@ src/step_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_sequencer_core
// Step note sequencer: pattern store, playhead, encoder settings and events.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_tvalid/in_tready. in_tuser carries the event
//   code (tick, start/stop, set current, pattern button, encoder, next
//   setting, test); in_tdata carries the button and encoder qualifiers.
//   Every accepted item produces exactly one result item on the out_ channel
//   with the note off/on events, sound trigger, LED mask and status.
//   The state updates at the accepting edge and the result is registered at
//   the same edge. One item per cycle is sustained while the receiver keeps
//   out_tready high; the single output register sets this, and a new item is
//   taken whenever that register is empty or is being drained in the same cycle.
//   If the receiver stalls, the result holds in the output register and
//   in_tready drops until it is taken; nothing is lost.
//   Reset (rst_n low, synchronous) loads the default pattern (a kick note on
//   every fourth step), stops playback, puts the playhead at step 0, note
//   39, velocity 127, tempo 120 and empties the output register.
// ----------------------------------------------------------------------------
module step_sequencer_core #(
  parameter int STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // step_index[3:0], clear_held[4], hold_held[5],
                                  // enc_dir[6], zero[7]
  input  logic [2:0]  in_tuser,   // op[2:0]
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // note_off_valid[0], note_off_number[7:1],
                                  // note_on_valid[8], note_on_number[15:9],
                                  // velocity[22:16], sound_trigger[23],
                                  // led_mask[39:24], beat_led[40],
                                  // tempo_bpm[48:41], note_selected[55:49],
                                  // setting_index[57:56], is_playing[58],
                                  // zero[63:59]
);
  import ssq_pkg::*;

  localparam int PW = $clog2(STEPS);

  // State.
  logic [NOTE_W-1:0]  pattern_r [STEPS];
  logic [NOTE_W-1:0]  pattern_nxt [STEPS];
  logic [PW-1:0]      position_r, position_nxt;
  logic [NOTE_W-1:0]  held_note_r, held_note_nxt;
  logic               running_r, running_nxt;
  logic [NOTE_W-1:0]  chosen_r, chosen_nxt;
  logic [NOTE_W-1:0]  velocity_r, velocity_nxt;
  logic [TEMPO_W-1:0] tempo_r, tempo_nxt;
  ssq_setting_t       setting_r, setting_nxt;

  // Output register.
  logic               out_valid_r;
  ssq_result_t        out_data_r, out_data_nxt;

  ssq_in_t            in_data;
  ssq_op_t            op;
  logic               accept;
  logic [NOTE_W-1:0]  step_note;
  logic [LED_W-1:0]   led_mask;
  logic               beat_led;

  assign in_data   = ssq_in_t'(in_tdata);
  assign op        = ssq_op_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign step_note = pattern_r[position_r];

  // Next state and event fields for the current item.
  always_comb begin
    pattern_nxt   = pattern_r;
    position_nxt  = position_r;
    held_note_nxt = held_note_r;
    running_nxt   = running_r;
    chosen_nxt    = chosen_r;
    velocity_nxt  = velocity_r;
    tempo_nxt     = tempo_r;
    setting_nxt   = setting_r;
    out_data_nxt  = '0;

    case (op)
      OP_TICK: begin
        if (running_r) begin
          if (held_note_r != '0) begin
            out_data_nxt.note_off_valid  = 1'b1;
            out_data_nxt.note_off_number = held_note_r;
          end
          if (step_note != '0) begin
            out_data_nxt.note_on_valid  = 1'b1;
            out_data_nxt.note_on_number = step_note;
            out_data_nxt.sound_trigger  = 1'b1;
            held_note_nxt               = step_note;
          end
        end
        if (!in_data.hold_held) begin
          position_nxt = (position_r == PW'(STEPS - 1)) ? '0 : position_r + 1'b1;
        end
      end
      OP_START_STOP: begin
        if (in_data.clear_held) begin
          for (int j = 0; j < STEPS; j++) begin
            pattern_nxt[j] = '0;
          end
        end else if (!running_r) begin
          position_nxt = '0;
          running_nxt  = 1'b1;
        end else begin
          running_nxt = 1'b0;
          if (held_note_r != '0) begin
            out_data_nxt.note_off_valid  = 1'b1;
            out_data_nxt.note_off_number = held_note_r;
          end
          held_note_nxt = '0;
        end
      end
      OP_SET_CURRENT: begin
        if (running_r) begin
          pattern_nxt[position_r] = chosen_r;
        end
      end
      OP_PATTERN_BTN: begin
        for (int j = 0; j < STEPS; j++) begin
          if (int'(in_data.step_index) == j) begin
            pattern_nxt[j] = in_data.clear_held ? '0 : chosen_r;
          end
        end
      end
      OP_ENCODER: begin
        case (setting_r)
          SET_NOTE: begin
            if (in_data.enc_dir) begin
              if (chosen_r > NOTE_MIN) chosen_nxt = chosen_r - 1'b1;
            end else begin
              if (chosen_r < NOTE_MAX) chosen_nxt = chosen_r + 1'b1;
            end
          end
          SET_TEMPO: begin
            if (in_data.enc_dir) begin
              if (tempo_r > TEMPO_MIN) tempo_nxt = tempo_r - 1'b1;
            end else begin
              if (tempo_r < TEMPO_MAX) tempo_nxt = tempo_r + 1'b1;
            end
          end
          SET_VELOCITY: begin
            if (in_data.enc_dir) begin
              if (velocity_r > VEL_MIN) velocity_nxt = velocity_r - 1'b1;
            end else begin
              if (velocity_r < VEL_MAX) velocity_nxt = velocity_r + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      OP_NEXT_SET: begin
        case (setting_r)
          SET_NOTE:  setting_nxt = SET_TEMPO;
          SET_TEMPO: setting_nxt = SET_VELOCITY;
          default:   setting_nxt = SET_NOTE;
        endcase
      end
      OP_TEST: begin
        out_data_nxt.note_on_valid   = 1'b1;
        out_data_nxt.note_on_number  = chosen_r;
        out_data_nxt.note_off_valid  = 1'b1;
        out_data_nxt.note_off_number = chosen_r;
        out_data_nxt.sound_trigger   = 1'b1;
      end
      default: begin
      end
    endcase

    // Status reflects the state after this item.
    out_data_nxt.velocity      = velocity_nxt;
    out_data_nxt.led_mask      = led_mask;
    out_data_nxt.beat_led      = beat_led;
    out_data_nxt.tempo_bpm     = tempo_nxt;
    out_data_nxt.note_selected = chosen_nxt;
    out_data_nxt.setting_index = setting_nxt;
    out_data_nxt.is_playing    = running_nxt;
  end

  // LED view of the updated state.
  ssq_led_map #(
    .STEPS (STEPS),
    .PW    (PW)
  ) u_led_map (
    .pattern     (pattern_nxt),
    .chosen_note (chosen_nxt),
    .running     (running_nxt),
    .position    (position_nxt),
    .led_mask    (led_mask),
    .beat_led    (beat_led)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < STEPS; j++) begin
        pattern_r[j] <= (j % 4 == 0) ? RST_BEAT_NOTE : '0;
      end
      position_r  <= '0;
      held_note_r <= '0;
      running_r   <= 1'b0;
      chosen_r    <= RST_CHOSEN;
      velocity_r  <= RST_VELOCITY;
      tempo_r     <= RST_TEMPO;
      setting_r   <= SET_NOTE;
    end else if (accept) begin
      pattern_r   <= pattern_nxt;
      position_r  <= position_nxt;
      held_note_r <= held_note_nxt;
      running_r   <= running_nxt;
      chosen_r    <= chosen_nxt;
      velocity_r  <= velocity_nxt;
      tempo_r     <= tempo_nxt;
      setting_r   <= setting_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // An accepted item always leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted item produced no result");

  // Every note on from this block also starts sample playback.
  a_trigger_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_data_r.sound_trigger == out_data_r.note_on_valid))
    else $error("sound trigger and note on disagree");

  // Tempo never reaches zero.
  a_tempo_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_data_r.tempo_bpm != '0))
    else $error("tempo reported as zero");

  // Stopping ends playback and releases the held note.
  a_held_off: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_START_STOP && !in_data.clear_held && running_r)
      |=> (held_note_r == '0) && !running_r)
    else $error("stop left a held note or kept playing");
`endif

endmodule

@@ src/ssq_led_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_led_map
// Builds the step LED mask (steps holding the selected note, toggled by the
// playhead while playing) and the beat LED from the updated state.
// ----------------------------------------------------------------------------
module ssq_led_map #(
  parameter int STEPS = 16,
  parameter int PW    = 4
) (
  input  logic [ssq_pkg::NOTE_W-1:0] pattern [STEPS],
  input  logic [ssq_pkg::NOTE_W-1:0] chosen_note,
  input  logic                       running,
  input  logic [PW-1:0]              position,
  output logic [ssq_pkg::LED_W-1:0]  led_mask,
  output logic                       beat_led
);
  import ssq_pkg::*;

  logic [PW+1:0] pos_ext;

  // One LED per step; steps beyond the pattern stay dark.
  for (genvar g = 0; g < LED_W; g++) begin : g_led
    if (g < STEPS) begin : g_on
      assign led_mask[g] = (pattern[g] == chosen_note) ^
                           (running && (position == PW'(g)));
    end else begin : g_off
      assign led_mask[g] = 1'b0;
    end
  end

  // Beat LED lights on every fourth step.
  assign pos_ext  = {2'b00, position};
  assign beat_led = (pos_ext[1:0] == 2'b00);

endmodule
